/* hdl/kf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf_pkg
// Shared types, constants, micro-op encoding and the control store of the
// position/velocity Kalman filter.
// ----------------------------------------------------------------------------
package kf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int WIDE_W        = 64;
    localparam int RAM_DEPTH     = 32;
    localparam int RAM_AW        = 5;
    localparam int PC_W          = 7;
    localparam int CFG_AW        = 3;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_QPOS  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_QVEL  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_RPOS  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_RVEL  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_X0    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_V0    = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_P0POS = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_P0VEL = 3'd7;

    // configuration reset values
    localparam logic [30:0] RST_QPOS  = 31'd6554;
    localparam logic [30:0] RST_QVEL  = 31'd32768;
    localparam logic [30:0] RST_RPOS  = 31'd65536;
    localparam logic [30:0] RST_RVEL  = 31'd32768;
    localparam logic [31:0] RST_X0    = 32'd0;
    localparam logic [31:0] RST_V0    = 32'd0;
    localparam logic [30:0] RST_P0POS = 31'd6553600;
    localparam logic [30:0] RST_P0VEL = 31'd655360;

    // operation codes of an input transfer
    localparam logic [2:0] OP_INIT    = 3'd0;
    localparam logic [2:0] OP_PREDICT = 3'd1;
    localparam logic [2:0] OP_PRED_AC = 3'd2;
    localparam logic [2:0] OP_UPD_POS = 3'd3;
    localparam logic [2:0] OP_UPD_BTH = 3'd4;

    // micro-op codes
    localparam logic [3:0] UOP_MOV   = 4'd0;
    localparam logic [3:0] UOP_ADD   = 4'd1;
    localparam logic [3:0] UOP_SUB   = 4'd2;
    localparam logic [3:0] UOP_NEG   = 4'd3;
    localparam logic [3:0] UOP_MUL   = 4'd4;
    localparam logic [3:0] UOP_DIV   = 4'd5;
    localparam logic [3:0] UOP_SQRT  = 4'd6;
    localparam logic [3:0] UOP_JMP   = 4'd7;
    localparam logic [3:0] UOP_JZ    = 4'd8;
    localparam logic [3:0] UOP_JLE   = 4'd9;
    localparam logic [3:0] UOP_SKIPF = 4'd10;
    localparam logic [3:0] UOP_OUT   = 4'd11;

    // operand sources: bit 5 clear selects a register file entry
    localparam logic [5:0] S_POS   = 6'd0;
    localparam logic [5:0] S_VEL   = 6'd1;
    localparam logic [5:0] S_P0    = 6'd2;
    localparam logic [5:0] S_P1    = 6'd3;
    localparam logic [5:0] S_P2    = 6'd4;
    localparam logic [5:0] S_P3    = 6'd5;
    localparam logic [5:0] S_T0    = 6'd6;
    localparam logic [5:0] S_T1    = 6'd7;
    localparam logic [5:0] S_T2    = 6'd8;
    localparam logic [5:0] S_T3    = 6'd9;
    localparam logic [5:0] S_T4    = 6'd10;
    localparam logic [5:0] S_T5    = 6'd11;
    localparam logic [5:0] S_T6    = 6'd12;
    localparam logic [5:0] S_T7    = 6'd13;
    localparam logic [5:0] S_T8    = 6'd14;
    localparam logic [5:0] S_T9    = 6'd15;
    localparam logic [5:0] S_T10   = 6'd16;
    localparam logic [5:0] S_T11   = 6'd17;
    localparam logic [5:0] S_T12   = 6'd18;
    localparam logic [5:0] S_QPOS  = 6'd32;
    localparam logic [5:0] S_QVEL  = 6'd33;
    localparam logic [5:0] S_RPOS  = 6'd34;
    localparam logic [5:0] S_RVEL  = 6'd35;
    localparam logic [5:0] S_X0    = 6'd36;
    localparam logic [5:0] S_V0    = 6'd37;
    localparam logic [5:0] S_P0POS = 6'd38;
    localparam logic [5:0] S_P0VEL = 6'd39;
    localparam logic [5:0] S_DT    = 6'd40;
    localparam logic [5:0] S_ACC   = 6'd41;
    localparam logic [5:0] S_ZP    = 6'd42;
    localparam logic [5:0] S_ZV    = 6'd43;
    localparam logic [5:0] S_ONE   = 6'd44;
    localparam logic [5:0] S_HALF  = 6'd45;
    localparam logic [5:0] S_ZERO  = 6'd46;

    // program entry points
    localparam logic [PC_W-1:0] PC_INIT    = 7'd0;
    localparam logic [PC_W-1:0] PC_PRED    = 7'd7;
    localparam logic [PC_W-1:0] PC_PREDCOV = 7'd9;
    localparam logic [PC_W-1:0] PC_PRED_AC = 7'd21;
    localparam logic [PC_W-1:0] PC_UPD_POS = 7'd30;
    localparam logic [PC_W-1:0] PC_UPD_K   = 7'd34;
    localparam logic [PC_W-1:0] PC_UPD_BTH = 7'd52;
    localparam logic [PC_W-1:0] PC_SKIP    = 7'd108;
    localparam logic [PC_W-1:0] PC_FIN     = 7'd109;

    typedef struct packed {
        logic [3:0]      opc;
        logic [4:0]      dst;
        logic [5:0]      sa;
        logic [5:0]      sb;
        logic [PC_W-1:0] tgt;
    } kf_uop_t;

    function automatic kf_uop_t mk(input logic [3:0] opc, input logic [5:0] d,
                                   input logic [5:0] a, input logic [5:0] b,
                                   input logic [PC_W-1:0] t);
        kf_uop_t u;
        u.opc = opc;
        u.dst = d[4:0];
        u.sa  = a;
        u.sb  = b;
        u.tgt = t;
        return u;
    endfunction

    // saturate a 33-bit signed sum to 32 bits
    function automatic logic [31:0] sat33(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // saturate a 64-bit signed value to 32 bits
    function automatic logic [31:0] sat64(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sh0000_0000_7fff_ffff) begin
            r = 32'h7fff_ffff;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [PC_W-1:0] kf_entry(input logic [2:0] op);
        logic [PC_W-1:0] p;
        unique case (op)
            OP_INIT:    p = PC_INIT;
            OP_PREDICT: p = PC_PRED;
            OP_PRED_AC: p = PC_PRED_AC;
            OP_UPD_POS: p = PC_UPD_POS;
            OP_UPD_BTH: p = PC_UPD_BTH;
            default:    p = PC_FIN;
        endcase
        return p;
    endfunction

    // control store
    function automatic kf_uop_t kf_rom(input logic [PC_W-1:0] pc);
        kf_uop_t u;
        unique case (pc)
            // init from configuration
            7'd0:   u = mk(UOP_MOV, S_POS, S_X0, S_ZERO, '0);
            7'd1:   u = mk(UOP_MOV, S_VEL, S_V0, S_ZERO, '0);
            7'd2:   u = mk(UOP_MOV, S_P0, S_P0POS, S_ZERO, '0);
            7'd3:   u = mk(UOP_MOV, S_P1, S_ZERO, S_ZERO, '0);
            7'd4:   u = mk(UOP_MOV, S_P2, S_ZERO, S_ZERO, '0);
            7'd5:   u = mk(UOP_MOV, S_P3, S_P0VEL, S_ZERO, '0);
            7'd6:   u = mk(UOP_JMP, S_T0, S_ZERO, S_ZERO, PC_FIN);
            // constant-velocity predict
            7'd7:   u = mk(UOP_MUL, S_T0, S_VEL, S_DT, '0);
            7'd8:   u = mk(UOP_ADD, S_POS, S_POS, S_T0, '0);
            // covariance predict
            7'd9:   u = mk(UOP_MUL, S_T0, S_DT, S_P2, '0);
            7'd10:  u = mk(UOP_ADD, S_T0, S_P0, S_T0, '0);
            7'd11:  u = mk(UOP_MUL, S_T1, S_DT, S_P3, '0);
            7'd12:  u = mk(UOP_ADD, S_T1, S_P1, S_T1, '0);
            7'd13:  u = mk(UOP_MUL, S_T2, S_T1, S_DT, '0);
            7'd14:  u = mk(UOP_ADD, S_T0, S_T0, S_T2, '0);
            7'd15:  u = mk(UOP_ADD, S_P0, S_T0, S_QPOS, '0);
            7'd16:  u = mk(UOP_MOV, S_P1, S_T1, S_ZERO, '0);
            7'd17:  u = mk(UOP_MUL, S_T2, S_P3, S_DT, '0);
            7'd18:  u = mk(UOP_ADD, S_P2, S_P2, S_T2, '0);
            7'd19:  u = mk(UOP_ADD, S_P3, S_P3, S_QVEL, '0);
            7'd20:  u = mk(UOP_JMP, S_T0, S_ZERO, S_ZERO, PC_FIN);
            // predict with acceleration
            7'd21:  u = mk(UOP_MUL, S_T0, S_HALF, S_ACC, '0);
            7'd22:  u = mk(UOP_MUL, S_T0, S_T0, S_DT, '0);
            7'd23:  u = mk(UOP_MUL, S_T0, S_T0, S_DT, '0);
            7'd24:  u = mk(UOP_MUL, S_T1, S_VEL, S_DT, '0);
            7'd25:  u = mk(UOP_ADD, S_T0, S_T1, S_T0, '0);
            7'd26:  u = mk(UOP_ADD, S_POS, S_POS, S_T0, '0);
            7'd27:  u = mk(UOP_MUL, S_T1, S_ACC, S_DT, '0);
            7'd28:  u = mk(UOP_ADD, S_VEL, S_VEL, S_T1, '0);
            7'd29:  u = mk(UOP_JMP, S_T0, S_ZERO, S_ZERO, PC_PREDCOV);
            // position update
            7'd30:  u = mk(UOP_ADD, S_T0, S_P0, S_RPOS, '0);
            7'd31:  u = mk(UOP_MOV, S_T1, S_ZERO, S_ZERO, '0);
            7'd32:  u = mk(UOP_JLE, S_T0, S_T0, S_ZERO, PC_UPD_K);
            7'd33:  u = mk(UOP_DIV, S_T1, S_ONE, S_T0, '0);
            7'd34:  u = mk(UOP_MUL, S_T2, S_P0, S_T1, '0);
            7'd35:  u = mk(UOP_MUL, S_T3, S_P2, S_T1, '0);
            7'd36:  u = mk(UOP_SUB, S_T4, S_ZP, S_POS, '0);
            7'd37:  u = mk(UOP_MUL, S_T5, S_T2, S_T4, '0);
            7'd38:  u = mk(UOP_ADD, S_POS, S_POS, S_T5, '0);
            7'd39:  u = mk(UOP_MUL, S_T5, S_T3, S_T4, '0);
            7'd40:  u = mk(UOP_ADD, S_VEL, S_VEL, S_T5, '0);
            7'd41:  u = mk(UOP_SUB, S_T5, S_ONE, S_T2, '0);
            7'd42:  u = mk(UOP_NEG, S_T6, S_T3, S_ZERO, '0);
            7'd43:  u = mk(UOP_MUL, S_T7, S_T5, S_P0, '0);
            7'd44:  u = mk(UOP_MUL, S_T8, S_T5, S_P1, '0);
            7'd45:  u = mk(UOP_MUL, S_T9, S_T6, S_P0, '0);
            7'd46:  u = mk(UOP_ADD, S_P2, S_T9, S_P2, '0);
            7'd47:  u = mk(UOP_MUL, S_T9, S_T6, S_P1, '0);
            7'd48:  u = mk(UOP_ADD, S_P3, S_T9, S_P3, '0);
            7'd49:  u = mk(UOP_MOV, S_P0, S_T7, S_ZERO, '0);
            7'd50:  u = mk(UOP_MOV, S_P1, S_T8, S_ZERO, '0);
            7'd51:  u = mk(UOP_JMP, S_T0, S_ZERO, S_ZERO, PC_FIN);
            // joint update
            7'd52:  u = mk(UOP_ADD, S_T0, S_P0, S_RPOS, '0);
            7'd53:  u = mk(UOP_ADD, S_T1, S_P3, S_RVEL, '0);
            7'd54:  u = mk(UOP_MUL, S_T2, S_T0, S_T1, '0);
            7'd55:  u = mk(UOP_MUL, S_T3, S_P1, S_P2, '0);
            7'd56:  u = mk(UOP_SUB, S_T2, S_T2, S_T3, '0);
            7'd57:  u = mk(UOP_JZ, S_T0, S_T2, S_ZERO, PC_SKIP);
            7'd58:  u = mk(UOP_DIV, S_T3, S_ONE, S_T2, '0);
            7'd59:  u = mk(UOP_MUL, S_T4, S_T1, S_T3, '0);
            7'd60:  u = mk(UOP_NEG, S_T5, S_P1, S_ZERO, '0);
            7'd61:  u = mk(UOP_MUL, S_T5, S_T5, S_T3, '0);
            7'd62:  u = mk(UOP_NEG, S_T6, S_P2, S_ZERO, '0);
            7'd63:  u = mk(UOP_MUL, S_T6, S_T6, S_T3, '0);
            7'd64:  u = mk(UOP_MUL, S_T7, S_T0, S_T3, '0);
            7'd65:  u = mk(UOP_MUL, S_T8, S_P0, S_T4, '0);
            7'd66:  u = mk(UOP_MUL, S_T9, S_P1, S_T6, '0);
            7'd67:  u = mk(UOP_ADD, S_T8, S_T8, S_T9, '0);
            7'd68:  u = mk(UOP_MUL, S_T9, S_P0, S_T5, '0);
            7'd69:  u = mk(UOP_MUL, S_T10, S_P1, S_T7, '0);
            7'd70:  u = mk(UOP_ADD, S_T9, S_T9, S_T10, '0);
            7'd71:  u = mk(UOP_MUL, S_T10, S_P2, S_T4, '0);
            7'd72:  u = mk(UOP_MUL, S_T11, S_P3, S_T6, '0);
            7'd73:  u = mk(UOP_ADD, S_T10, S_T10, S_T11, '0);
            7'd74:  u = mk(UOP_MUL, S_T11, S_P2, S_T5, '0);
            7'd75:  u = mk(UOP_MUL, S_T12, S_P3, S_T7, '0);
            7'd76:  u = mk(UOP_ADD, S_T11, S_T11, S_T12, '0);
            7'd77:  u = mk(UOP_SUB, S_T0, S_ZP, S_POS, '0);
            7'd78:  u = mk(UOP_SUB, S_T1, S_ZV, S_VEL, '0);
            7'd79:  u = mk(UOP_MUL, S_T2, S_T8, S_T0, '0);
            7'd80:  u = mk(UOP_MUL, S_T3, S_T9, S_T1, '0);
            7'd81:  u = mk(UOP_ADD, S_T2, S_T2, S_T3, '0);
            7'd82:  u = mk(UOP_ADD, S_POS, S_POS, S_T2, '0);
            7'd83:  u = mk(UOP_MUL, S_T2, S_T10, S_T0, '0);
            7'd84:  u = mk(UOP_MUL, S_T3, S_T11, S_T1, '0);
            7'd85:  u = mk(UOP_ADD, S_T2, S_T2, S_T3, '0);
            7'd86:  u = mk(UOP_ADD, S_VEL, S_VEL, S_T2, '0);
            7'd87:  u = mk(UOP_SUB, S_T0, S_ONE, S_T8, '0);
            7'd88:  u = mk(UOP_NEG, S_T1, S_T9, S_ZERO, '0);
            7'd89:  u = mk(UOP_NEG, S_T2, S_T10, S_ZERO, '0);
            7'd90:  u = mk(UOP_SUB, S_T3, S_ONE, S_T11, '0);
            7'd91:  u = mk(UOP_MUL, S_T4, S_T0, S_P0, '0);
            7'd92:  u = mk(UOP_MUL, S_T5, S_T1, S_P2, '0);
            7'd93:  u = mk(UOP_ADD, S_T4, S_T4, S_T5, '0);
            7'd94:  u = mk(UOP_MUL, S_T5, S_T0, S_P1, '0);
            7'd95:  u = mk(UOP_MUL, S_T6, S_T1, S_P3, '0);
            7'd96:  u = mk(UOP_ADD, S_T5, S_T5, S_T6, '0);
            7'd97:  u = mk(UOP_MUL, S_T6, S_T2, S_P0, '0);
            7'd98:  u = mk(UOP_MUL, S_T7, S_T3, S_P2, '0);
            7'd99:  u = mk(UOP_ADD, S_T6, S_T6, S_T7, '0);
            7'd100: u = mk(UOP_MUL, S_T7, S_T2, S_P1, '0);
            7'd101: u = mk(UOP_MUL, S_T8, S_T3, S_P3, '0);
            7'd102: u = mk(UOP_ADD, S_T7, S_T7, S_T8, '0);
            7'd103: u = mk(UOP_MOV, S_P0, S_T4, S_ZERO, '0);
            7'd104: u = mk(UOP_MOV, S_P1, S_T5, S_ZERO, '0);
            7'd105: u = mk(UOP_MOV, S_P2, S_T6, S_ZERO, '0);
            7'd106: u = mk(UOP_MOV, S_P3, S_T7, S_ZERO, '0);
            7'd107: u = mk(UOP_JMP, S_T0, S_ZERO, S_ZERO, PC_FIN);
            // singular innovation matrix
            7'd108: u = mk(UOP_SKIPF, S_T0, S_ZERO, S_ZERO, '0);
            // common tail: std deviation, then the result transfer
            7'd109: u = mk(UOP_SQRT, S_T0, S_P0, S_ZERO, '0);
            7'd110: u = mk(UOP_OUT, S_T0, S_POS, S_VEL, '0);
            default: u = mk(UOP_JMP, S_T0, S_ZERO, S_ZERO, PC_FIN);
        endcase
        return u;
    endfunction

endpackage

/* hdl/kf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module kf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* hdl/kf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf_div
// Fixed-point divide (num * 2^FRAC_BITS) / den, truncated toward zero and
// saturated. Restoring radix-2, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kf_div
    import kf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quot
);

    localparam int CNT_W = $clog2(WIDE_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [WIDE_W-1:0] dq_reg, dq_next;
    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       dvs_reg, dvs_next;
    logic [31:0]       quot_reg, quot_next;
    logic [31:0]       num_mag, den_mag;
    logic [32:0]       rem_sh;
    logic              qbit;
    logic [WIDE_W-1:0] dq_new;

    always_comb begin
        num_mag   = num[31] ? (~num + 32'd1) : num;
        den_mag   = den[31] ? (~den + 32'd1) : den;
        rem_sh    = {rem_reg, dq_reg[WIDE_W-1]};
        qbit      = (rem_sh >= {1'b0, dvs_reg});
        dq_new    = {dq_reg[WIDE_W-2:0], qbit};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = num[31] ^ den[31];
            dq_next   = WIDE_W'(num_mag) << FRAC_BITS;
            rem_next  = '0;
            dvs_next  = den_mag;
        end else if (busy_reg) begin
            dq_next  = dq_new;
            rem_next = qbit ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WIDE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg) begin
                    quot_next = (dq_new > WIDE_W'(64'h8000_0000)) ? 32'h8000_0000
                                                                  : (~dq_new[31:0] + 32'd1);
                end else begin
                    quot_next = (dq_new > WIDE_W'(64'h7fff_ffff)) ? 32'h7fff_ffff
                                                                  : dq_new[31:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg  <= neg_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* hdl/kf_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf_sqrt
// Integer square root of value * 2^FRAC_BITS, bit-pair per cycle; zero for
// a value that is zero or negative.
// ----------------------------------------------------------------------------
module kf_sqrt
    import kf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] value,
    output logic        done,
    output logic [30:0] root
);

    localparam int ITER  = WIDE_W / 2;
    localparam int CNT_W = $clog2(ITER);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WIDE_W-1:0] v_reg, v_next;
    logic [WIDE_W-1:0] res_reg, res_next;
    logic [WIDE_W-1:0] bit_reg, bit_next;
    logic [WIDE_W-1:0] trial;

    always_comb begin
        trial     = res_reg + bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            // non-positive variance runs through as zero and yields zero
            v_next    = (!value[31] && value != '0) ? (WIDE_W'(value) << FRAC_BITS) : '0;
            res_next  = '0;
            bit_next  = WIDE_W'(1) << (WIDE_W - 2);
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ITER - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[30:0];

endmodule

/* hdl/kalman_filter_pos_vel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_filter_pos_vel
// Two-state (position, velocity) Kalman filter in signed fixed point, run by
// a microcoded sequencer over a register file, a multiplier, a divider and a
// square-root unit.
// ----------------------------------------------------------------------------
// Micro-ops: an ALU or multiply micro-op runs fetch, execute and write; a jump
//   or flag step runs fetch and execute; a divide or square root waits in a
//   wait phase for its unit. The output step holds while the previous result
//   still waits for m_tready.
// Throughput: one item at a time; the next transfer can be taken from the
//   cycle in which m_tvalid rises.
// Reset: synchronous, active low; afterwards a boot pass loads the start
//   state from the configuration before s_tready rises.
module kalman_filter_pos_vel
    import kf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write port
    input  logic              cfg_wen,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [31:0]       cfg_wdata,
    // input channel
    input  logic              s_tvalid,
    output logic              s_tready,
    // time_step[30:0], acceleration[62:31], measured_position[94:63],
    // measured_velocity[126:95], zero pad [127]
    input  logic [127:0]      s_tdata,
    // operation[2:0]
    input  logic [2:0]        s_tuser,
    // result channel
    output logic              m_tvalid,
    input  logic              m_tready,
    // position_estimate[31:0], velocity_estimate[63:32], position_std[94:64],
    // zero pad [95]
    output logic [95:0]       m_tdata,
    // update_skipped[0]
    output logic [0:0]        m_tuser
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_FETCH = 3'd1;
    localparam logic [2:0] PH_EXEC  = 3'd2;
    localparam logic [2:0] PH_WAIT  = 3'd3;
    localparam logic [2:0] PH_WB    = 3'd4;

    localparam logic [31:0] ONE_Q  = 32'(64'd1 << FRAC_BITS);
    localparam logic [31:0] HALF_Q = 32'(64'd1 << (FRAC_BITS - 1));

    logic [2:0]       phase_reg, phase_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic             boot_reg, boot_next;

    logic [30:0]      qpos_reg, qpos_next, qvel_reg, qvel_next;
    logic [30:0]      rpos_reg, rpos_next, rvel_reg, rvel_next;
    logic [31:0]      x0_reg, x0_next, v0_reg, v0_next;
    logic [30:0]      p0pos_reg, p0pos_next, p0vel_reg, p0vel_next;

    logic [30:0]      dt_reg, dt_next;
    logic [31:0]      acc_reg, acc_next, zp_reg, zp_next, zv_reg, zv_next;

    logic [31:0]        res_reg, res_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [30:0]        std_reg, std_next;
    logic               skip_reg, skip_next;
    logic               m_valid_reg, m_valid_next;
    logic [95:0]        m_data_reg, m_data_next;
    logic               m_user_reg, m_user_next;

    kf_uop_t          uop;
    logic [31:0]      rd_a, rd_b, opa, opb;
    logic             ram_we;
    logic [31:0]      ram_wdata;
    logic signed [63:0] prod_sh;
    logic             div_start, div_done, sqrt_start, sqrt_done;
    logic [31:0]      div_q;
    logic [30:0]      sqrt_q;

    assign uop = kf_rom(pc_reg);

    function automatic logic [31:0] spec_val(input logic [5:0] src);
        logic [31:0] r;
        unique case (src)
            S_QPOS:  r = {1'b0, qpos_reg};
            S_QVEL:  r = {1'b0, qvel_reg};
            S_RPOS:  r = {1'b0, rpos_reg};
            S_RVEL:  r = {1'b0, rvel_reg};
            S_X0:    r = x0_reg;
            S_V0:    r = v0_reg;
            S_P0POS: r = {1'b0, p0pos_reg};
            S_P0VEL: r = {1'b0, p0vel_reg};
            S_DT:    r = {1'b0, dt_reg};
            S_ACC:   r = acc_reg;
            S_ZP:    r = zp_reg;
            S_ZV:    r = zv_reg;
            S_ONE:   r = ONE_Q;
            S_HALF:  r = HALF_Q;
            default: r = '0;
        endcase
        return r;
    endfunction

    kf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_rf (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (uop.dst),
        .wdata   (ram_wdata),
        .raddr_a (uop.sa[RAM_AW-1:0]),
        .raddr_b (uop.sb[RAM_AW-1:0]),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    kf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (opa),
        .den     (opb),
        .done    (div_done),
        .quot    (div_q)
    );

    kf_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .value   (opa),
        .done    (sqrt_done),
        .root    (sqrt_q)
    );

    assign opa       = uop.sa[5] ? spec_val(uop.sa) : rd_a;
    assign opb       = uop.sb[5] ? spec_val(uop.sb) : rd_b;
    // arithmetic shift is the floor of the scaled product
    assign prod_sh   = prod_reg >>> FRAC_BITS;
    assign ram_wdata = (uop.opc == UOP_MUL) ? sat64(prod_sh) : res_reg;

    always_comb begin
        phase_next   = phase_reg;
        pc_next      = pc_reg;
        boot_next    = boot_reg;
        qpos_next    = qpos_reg;
        qvel_next    = qvel_reg;
        rpos_next    = rpos_reg;
        rvel_next    = rvel_reg;
        x0_next      = x0_reg;
        v0_next      = v0_reg;
        p0pos_next   = p0pos_reg;
        p0vel_next   = p0vel_reg;
        dt_next      = dt_reg;
        acc_next     = acc_reg;
        zp_next      = zp_reg;
        zv_next      = zv_reg;
        res_next     = res_reg;
        prod_next    = prod_reg;
        std_next     = std_reg;
        skip_next    = skip_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        ram_we       = 1'b0;
        div_start    = 1'b0;
        sqrt_start   = 1'b0;

        if (cfg_wen) begin
            unique case (cfg_addr)
                CFG_QPOS:  qpos_next  = cfg_wdata[30:0];
                CFG_QVEL:  qvel_next  = cfg_wdata[30:0];
                CFG_RPOS:  rpos_next  = cfg_wdata[30:0];
                CFG_RVEL:  rvel_next  = cfg_wdata[30:0];
                CFG_X0:    x0_next    = cfg_wdata;
                CFG_V0:    v0_next    = cfg_wdata;
                CFG_P0POS: p0pos_next = cfg_wdata[30:0];
                CFG_P0VEL: p0vel_next = cfg_wdata[30:0];
                default: ;
            endcase
        end

        unique case (phase_reg)
            PH_IDLE: begin
                if (s_tvalid) begin
                    dt_next    = s_tdata[30:0];
                    acc_next   = s_tdata[62:31];
                    zp_next    = s_tdata[94:63];
                    zv_next    = s_tdata[126:95];
                    skip_next  = 1'b0;
                    pc_next    = kf_entry(s_tuser);
                    phase_next = PH_FETCH;
                end
            end
            PH_FETCH: begin
                phase_next = PH_EXEC;
            end
            PH_EXEC: begin
                unique case (uop.opc)
                    UOP_MOV: begin
                        res_next   = opa;
                        phase_next = PH_WB;
                    end
                    UOP_ADD: begin
                        res_next   = sat33({opa[31], opa} + {opb[31], opb});
                        phase_next = PH_WB;
                    end
                    UOP_SUB: begin
                        res_next   = sat33({opa[31], opa} - {opb[31], opb});
                        phase_next = PH_WB;
                    end
                    UOP_NEG: begin
                        res_next   = sat33(33'd0 - {opa[31], opa});
                        phase_next = PH_WB;
                    end
                    UOP_MUL: begin
                        prod_next  = signed'(opa) * signed'(opb);
                        phase_next = PH_WB;
                    end
                    UOP_DIV: begin
                        div_start  = 1'b1;
                        phase_next = PH_WAIT;
                    end
                    UOP_SQRT: begin
                        sqrt_start = 1'b1;
                        phase_next = PH_WAIT;
                    end
                    UOP_JMP: begin
                        pc_next    = uop.tgt;
                        phase_next = PH_FETCH;
                    end
                    UOP_JZ: begin
                        pc_next    = (opa == '0) ? uop.tgt : pc_reg + 1'b1;
                        phase_next = PH_FETCH;
                    end
                    UOP_JLE: begin
                        pc_next    = (opa[31] || opa == '0) ? uop.tgt : pc_reg + 1'b1;
                        phase_next = PH_FETCH;
                    end
                    UOP_SKIPF: begin
                        skip_next  = 1'b1;
                        pc_next    = pc_reg + 1'b1;
                        phase_next = PH_FETCH;
                    end
                    UOP_OUT: begin
                        // hold here while the previous result is still unclaimed
                        if (!m_valid_reg || m_tready) begin
                            if (!boot_reg) begin
                                m_valid_next = 1'b1;
                                m_data_next  = {1'b0, std_reg, opb, opa};
                                m_user_next  = skip_reg;
                            end
                            boot_next  = 1'b0;
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        pc_next    = pc_reg + 1'b1;
                        phase_next = PH_FETCH;
                    end
                endcase
            end
            PH_WAIT: begin
                if (uop.opc == UOP_DIV) begin
                    if (div_done) begin
                        res_next   = div_q;
                        phase_next = PH_WB;
                    end
                end else if (sqrt_done) begin
                    std_next   = sqrt_q;
                    pc_next    = pc_reg + 1'b1;
                    phase_next = PH_FETCH;
                end
            end
            PH_WB: begin
                ram_we     = 1'b1;
                pc_next    = pc_reg + 1'b1;
                phase_next = PH_FETCH;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FETCH;
            pc_reg      <= PC_INIT;
            boot_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
            skip_reg    <= 1'b0;
            qpos_reg    <= RST_QPOS;
            qvel_reg    <= RST_QVEL;
            rpos_reg    <= RST_RPOS;
            rvel_reg    <= RST_RVEL;
            x0_reg      <= RST_X0;
            v0_reg      <= RST_V0;
            p0pos_reg   <= RST_P0POS;
            p0vel_reg   <= RST_P0VEL;
        end else begin
            phase_reg   <= phase_next;
            pc_reg      <= pc_next;
            boot_reg    <= boot_next;
            m_valid_reg <= m_valid_next;
            skip_reg    <= skip_next;
            qpos_reg    <= qpos_next;
            qvel_reg    <= qvel_next;
            rpos_reg    <= rpos_next;
            rvel_reg    <= rvel_next;
            x0_reg      <= x0_next;
            v0_reg      <= v0_next;
            p0pos_reg   <= p0pos_next;
            p0vel_reg   <= p0vel_next;
        end
        dt_reg     <= dt_next;
        acc_reg    <= acc_next;
        zp_reg     <= zp_next;
        zv_reg     <= zv_next;
        res_reg    <= res_next;
        prod_reg   <= prod_next;
        std_reg    <= std_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign s_tready   = (phase_reg == PH_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (phase_reg == PH_FETCH && !skip_reg))
        else $error("accepted transfer did not start the program");

    a_div_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (phase_reg == PH_WAIT && uop.opc == UOP_DIV))
        else $error("divider finished outside a divide step");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(phase_reg) == PH_EXEC && !$past(boot_reg)))
        else $error("result raised outside an output step");
`endif

endmodule
